### hdl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// Deadline timer queue package
// Shared types, codes and default sizes for the deadline timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 64;
  localparam int unsigned DEF_TIME_WIDTH  = 32;
  localparam int unsigned MAX_RESULTS     = 64;
  localparam int unsigned KIND_W          = 2;
  localparam int unsigned ID_W            = 8;
  localparam int unsigned TMO_W           = 20;
  localparam int unsigned EV_W            = 3;

  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd2;

  localparam logic [TMO_W-1:0] WAIT_MAX = '1;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_ADD,
    OP_CANCEL
  } op_t;

  typedef enum logic [EV_W-1:0] {
    EV_ADDED     = 3'd0,
    EV_CANCELLED = 3'd1,
    EV_EXPIRED   = 3'd2,
    EV_TICK_NONE = 3'd3,
    EV_FULL      = 3'd4,
    EV_NOT_FOUND = 3'd5
  } event_t;

  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  id;
    logic [TMO_W-1:0] timeout;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_CMP,
    S_ADD_PUT,
    S_CAN_RD,
    S_CAN_CMP,
    S_TICK_RD,
    S_TICK_CMP,
    S_ST_RD,
    S_ST_CMP,
    S_OUT_RD,
    S_OUT_WR
  } state_t;

endpackage

`default_nettype wire

### hdl/deadline_timer_queue.sv
// ----------------------------------------------------------------------------
// Deadline timer queue
// Millisecond clock with a deadline-ordered queue of request timers.
// ----------------------------------------------------------------------------
// Items are taken one at a time by the engine while a two-entry input queue
// keeps accepting. Entries sit in one memory with a write port and a
// registered read port, so the engine reads an entry before it compares it.
// An add scans from the tail towards the head, moving each entry with a later
// deadline up by one, and then writes the new entry; a cancel scans from the
// head until it marks the matching entry or reaches the tail; a tick drops
// expired and cancelled entries from the head. Cancelled entries at the head
// are also dropped while the wait is worked out. Every result then passes a
// read state and a write state on the output side, which waits while the
// result channel stalls. No clearing pass follows reset.
`default_nettype none

module deadline_timer_queue import dtq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int unsigned TIME_WIDTH  = DEF_TIME_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [ID_W-1:0]   request_id,
  input  wire logic [TMO_W-1:0]  timeout_ms,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic [EV_W-1:0]        event_res,
  output logic [ID_W-1:0]        request_id_res,
  output logic [TMO_W-1:0]       next_wait_ms,
  output logic                   queue_empty,
  output logic                   last
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic          q_valid;
  item_t         q_item;
  logic          q_ready;
  logic [CW-1:0] entry_count;

  dtq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .kind       (kind),
    .request_id (request_id),
    .timeout_ms (timeout_ms),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_ready    (q_ready)
  );

  dtq_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_ready        (q_ready),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .event_res      (event_res),
    .request_id_res (request_id_res),
    .next_wait_ms   (next_wait_ms),
    .queue_empty    (queue_empty),
    .last           (last),
    .entry_count    (entry_count)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(QUEUE_DEPTH))
    else $error("Entry count exceeds the queue depth.");

  a_empty_wait: assert property (@(posedge clk) disable iff (rst)
    result_valid && queue_empty |-> next_wait_ms == '0)
    else $error("An empty queue reports a nonzero wait.");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && event_res != EV_EXPIRED |-> last)
    else $error("A single-result transfer is not marked last.");
`endif

endmodule

`default_nettype wire

### hdl/dtq_front.sv
// ----------------------------------------------------------------------------
// Deadline timer queue front end
// Accepts items, decodes the kind and holds items of a known kind in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_front import dtq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [ID_W-1:0]   request_id,
  input  wire logic [TMO_W-1:0]  timeout_ms,
  output logic                   q_valid,
  output item_t                  q_item,
  input  wire logic              q_ready
);

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       known;
  op_t        op;
  logic       push;
  logic       pop;

  always_comb begin
    known = 1'b1;
    op    = OP_TICK;
    unique case (kind)
      KIND_TICK:   op = OP_TICK;
      KIND_ADD:    op = OP_ADD;
      KIND_CANCEL: op = OP_CANCEL;
      default:     known = 1'b0;
    endcase
  end

  assign item_stall = (fill == 2'd2);
  assign push       = item_valid && !item_stall && known;
  assign q_valid    = (fill != 2'd0);
  assign q_item     = slot[rd_ptr];
  assign pop        = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{op: op, id: request_id, timeout: timeout_ms};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/dtq_engine.sv
// ----------------------------------------------------------------------------
// Deadline timer queue engine
// Keeps the clock and the ordered entry memory, executes add, cancel and
// tick, and streams the results through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_engine import dtq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int unsigned TIME_WIDTH  = DEF_TIME_WIDTH,
  localparam int unsigned AW  = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire item_t             q_item,
  output logic                   q_ready,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic [EV_W-1:0]        event_res,
  output logic [ID_W-1:0]        request_id_res,
  output logic [TMO_W-1:0]       next_wait_ms,
  output logic                   queue_empty,
  output logic                   last,
  output logic [CW-1:0]          entry_count
);

  localparam int unsigned TW  = TIME_WIDTH;
  localparam int unsigned RW  = $clog2(MAX_RESULTS + 1);
  localparam int unsigned RBW = $clog2(MAX_RESULTS);
  localparam logic [AW+1:0] DEPTH_X = (AW+2)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [RW-1:0] MAX_N   = RW'(MAX_RESULTS);

  logic [TW-1:0]   mem_dl [QUEUE_DEPTH];
  logic [ID_W-1:0] mem_id [QUEUE_DEPTH];
  logic            mem_cx [QUEUE_DEPTH];
  logic [ID_W-1:0] rbuf   [MAX_RESULTS];

  state_t          state;
  state_t          state_next;
  logic [TW-1:0]   now;
  logic [AW-1:0]   head;
  logic [CW-1:0]   count;
  logic [CW-1:0]   idx;
  logic [CW-1:0]   ins;
  logic [TW-1:0]   key;
  logic [ID_W-1:0] rid;
  event_t          code;
  logic [RW-1:0]   n;
  logic [RW-1:0]   k;
  logic [TMO_W-1:0] wait_q;
  logic            empty_q;
  logic [TW-1:0]   rd_dl;
  logic [ID_W-1:0] rd_id;
  logic            rd_cx;
  logic [ID_W-1:0] rb_q;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [TW-1:0]   wdl;
  logic [ID_W-1:0] wid;
  logic            wcx;
  logic [AW-1:0]   raddr;
  logic            ins_le;
  logic            head_due;
  logic            can_hit;
  logic            can_end;
  logic            out_free;
  logic            res_last;
  logic [TW-1:0]   diff;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
    logic [AW+1:0] s;
    s = (AW+2)'(h) + (AW+2)'(l);
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[AW-1:0];
  endfunction

  function automatic logic time_le(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW-1:0] d;
    d = b - a;
    return !d[TW-1];
  endfunction

  assign q_ready     = (state == S_IDLE);
  assign entry_count = count;
  assign ins_le      = time_le(rd_dl, key);
  assign head_due    = time_le(rd_dl, now);
  assign can_hit     = !rd_cx && (rd_id == rid);
  assign can_end     = (CW'(idx + 1'b1) == count);
  assign out_free    = !result_valid || !result_stall;
  assign res_last    = (n == '0) || (RW'(k + 1'b1) == n);
  assign diff        = rd_dl - now;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_item.op)
            OP_ADD: begin
              if (count == DEPTH_C) begin
                state_next = S_ST_RD;
              end else if (count == '0) begin
                state_next = S_ADD_PUT;
              end else begin
                state_next = S_ADD_RD;
              end
            end
            OP_CANCEL: state_next = (count == '0) ? S_ST_RD : S_CAN_RD;
            default:   state_next = S_TICK_RD;
          endcase
        end
      end
      S_ADD_RD:  state_next = S_ADD_CMP;
      S_ADD_CMP: begin
        if (ins_le || idx == '0) begin
          state_next = S_ADD_PUT;
        end else begin
          state_next = S_ADD_RD;
        end
      end
      S_ADD_PUT: state_next = S_ST_RD;
      S_CAN_RD:  state_next = S_CAN_CMP;
      S_CAN_CMP: state_next = (can_hit || can_end) ? S_ST_RD : S_CAN_RD;
      S_TICK_RD: state_next = (count == '0 || n == MAX_N) ? S_ST_RD : S_TICK_CMP;
      S_TICK_CMP: state_next = (rd_cx || head_due) ? S_TICK_RD : S_ST_RD;
      S_ST_RD:   state_next = (count == '0) ? S_OUT_RD : S_ST_CMP;
      S_ST_CMP:  state_next = rd_cx ? S_ST_RD : S_OUT_RD;
      S_OUT_RD:  state_next = S_OUT_WR;
      S_OUT_WR: begin
        if (out_free) begin
          state_next = res_last ? S_IDLE : S_OUT_RD;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = phys(head, idx);
    wdl   = rd_dl;
    wid   = rd_id;
    wcx   = rd_cx;
    raddr = phys(head, idx);
    unique case (state)
      S_ADD_CMP: begin
        if (!ins_le) begin
          we    = 1'b1;
          waddr = phys(head, CW'(idx + 1'b1));
        end
      end
      S_ADD_PUT: begin
        we    = 1'b1;
        waddr = phys(head, ins);
        wdl   = key;
        wid   = rid;
        wcx   = 1'b0;
      end
      S_CAN_CMP: begin
        if (can_hit) begin
          we  = 1'b1;
          wcx = 1'b1;
        end
      end
      S_TICK_RD, S_ST_RD: raddr = head;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_dl[waddr] <= wdl;
      mem_id[waddr] <= wid;
      mem_cx[waddr] <= wcx;
    end
    rd_dl <= mem_dl[raddr];
    rd_id <= mem_id[raddr];
    rd_cx <= mem_cx[raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_TICK_CMP && !rd_cx && head_due) begin
      rbuf[n[RBW-1:0]] <= rd_id;
    end
    rb_q <= rbuf[k[RBW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      now          <= '0;
      head         <= '0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT_WR && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            n   <= '0;
            k   <= '0;
            ins <= '0;
            key <= now + TW'(q_item.timeout);
            rid <= (q_item.op == OP_TICK) ? '0 : q_item.id;
            unique case (q_item.op)
              OP_ADD: begin
                idx  <= CW'(count - 1'b1);
                code <= (count == DEPTH_C) ? EV_FULL : EV_ADDED;
              end
              OP_CANCEL: begin
                idx  <= '0;
                code <= EV_NOT_FOUND;
              end
              default: begin
                now  <= now + 1'b1;
                code <= EV_TICK_NONE;
              end
            endcase
          end
        end
        S_ADD_CMP: begin
          if (ins_le) begin
            ins <= CW'(idx + 1'b1);
          end else if (idx == '0) begin
            ins <= '0;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        S_ADD_PUT: count <= count + 1'b1;
        S_CAN_CMP: begin
          if (can_hit) begin
            code <= EV_CANCELLED;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_TICK_CMP: begin
          if (rd_cx || head_due) begin
            head  <= phys(head, CW'(1));
            count <= count - 1'b1;
          end
          if (!rd_cx && head_due) begin
            n <= n + 1'b1;
          end
        end
        S_ST_RD: begin
          if (count == '0) begin
            wait_q  <= '0;
            empty_q <= 1'b1;
          end
        end
        S_ST_CMP: begin
          if (rd_cx) begin
            head  <= phys(head, CW'(1));
            count <= count - 1'b1;
          end else begin
            empty_q <= 1'b0;
            if (diff == '0 || diff[TW-1]) begin
              wait_q <= '0;
            end else if (diff > TW'(WAIT_MAX)) begin
              wait_q <= WAIT_MAX;
            end else begin
              wait_q <= diff[TMO_W-1:0];
            end
          end
        end
        S_OUT_WR: begin
          if (out_free) begin
            event_res      <= (n != '0) ? EV_EXPIRED : code;
            request_id_res <= (n != '0) ? rb_q : rid;
            next_wait_ms   <= wait_q;
            queue_empty    <= empty_q;
            last           <= res_last;
            k              <= k + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### tb/sv/deadline_timer_queue_checker.sv
// ----------------------------------------------------------------------------
// Deadline timer queue checker
// Watches the item and result channels. On each accepted item it works out
// the expected results from its own copy of the clock and the deadline queue.
// Each accepted result is then compared field by field with the oldest
// expected result still waiting.
// ----------------------------------------------------------------------------
module deadline_timer_queue_checker import dtq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  logic [KIND_W-1:0] kind,
  input  logic [ID_W-1:0]   request_id,
  input  logic [TMO_W-1:0]  timeout_ms,
  input  logic              result_valid,
  input  logic              result_stall,
  input  logic [EV_W-1:0]   event_res,
  input  logic [ID_W-1:0]   request_id_res,
  input  logic [TMO_W-1:0]  next_wait_ms,
  input  logic              queue_empty,
  input  logic              last,
  output int                failures,
  output int                pending,
  output int                held_entries
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEF_QUEUE_DEPTH;

  typedef struct packed {
    event_t           ev;
    logic [ID_W-1:0]  id;
    logic [TMO_W-1:0] wait_ms;
    logic             empty;
    logic             fin;
  } timer_result_t;

  typedef struct packed {
    logic [31:0]     deadline;
    logic [ID_W-1:0] id;
    logic            dropped;
  } timer_entry_t;

  timer_result_t expected_results[$];
  timer_entry_t  timer_queue[$];
  logic [31:0]   now_ms;

  assign pending      = expected_results.size();
  assign held_entries = timer_queue.size();

  function automatic logic not_later(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return !d[31];
  endfunction

  task automatic predict_item(logic [KIND_W-1:0] k, logic [ID_W-1:0] rid,
                              logic [TMO_W-1:0] tmo);
    timer_result_t batch[$];
    timer_result_t r;
    timer_entry_t  e;
    logic [31:0]   d;
    logic [TMO_W-1:0] w;
    logic          emp;
    int            pos;
    logic          found;
    if (k == KIND_TICK) begin
      now_ms = now_ms + 1;
      forever begin
        while (timer_queue.size() > 0 && timer_queue[0].dropped) void'(timer_queue.pop_front());
        if (timer_queue.size() == 0 || batch.size() >= MAX_RESULTS) break;
        if (!not_later(timer_queue[0].deadline, now_ms)) break;
        r = '0;
        r.ev = EV_EXPIRED;
        r.id = timer_queue[0].id;
        batch.push_back(r);
        void'(timer_queue.pop_front());
      end
      if (batch.size() == 0) begin
        r = '0;
        r.ev = EV_TICK_NONE;
        batch.push_back(r);
      end
    end else if (k == KIND_ADD) begin
      r = '0;
      r.id = rid;
      if (timer_queue.size() >= DEPTH) begin
        r.ev = EV_FULL;
      end else begin
        e.deadline = now_ms + 32'(tmo);
        e.id = rid;
        e.dropped = 1'b0;
        pos = 0;
        while (pos < timer_queue.size() && not_later(timer_queue[pos].deadline, e.deadline))
          pos++;
        timer_queue.insert(pos, e);
        r.ev = EV_ADDED;
      end
      batch.push_back(r);
    end else if (k == KIND_CANCEL) begin
      found = 1'b0;
      foreach (timer_queue[i]) begin
        if (!found && !timer_queue[i].dropped && timer_queue[i].id == rid) begin
          timer_queue[i].dropped = 1'b1;
          found = 1'b1;
        end
      end
      r = '0;
      r.id = rid;
      r.ev = found ? EV_CANCELLED : EV_NOT_FOUND;
      batch.push_back(r);
    end else begin
      return;
    end
    while (timer_queue.size() > 0 && timer_queue[0].dropped) void'(timer_queue.pop_front());
    if (timer_queue.size() == 0) begin
      w = '0;
      emp = 1'b1;
    end else begin
      d = timer_queue[0].deadline - now_ms;
      emp = 1'b0;
      if (d == 0 || d[31]) w = '0;
      else if (d > 32'(WAIT_MAX)) w = WAIT_MAX;
      else w = d[TMO_W-1:0];
    end
    foreach (batch[i]) begin
      batch[i].wait_ms = w;
      batch[i].empty = emp;
      batch[i].fin = (i == batch.size() - 1);
      expected_results.push_back(batch[i]);
    end
  endtask

  always @(posedge clk) begin
    timer_result_t x;
    if (rst) begin
      now_ms = '0;
      timer_queue.delete();
      expected_results.delete();
      failures <= 0;
    end else begin
      if (item_valid && !item_stall) predict_item(kind, request_id, timeout_ms);
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("Unexpected result transfer: event_res %0d", event_res);
          failures <= failures + 1;
        end else begin
          x = expected_results.pop_front();
          if (event_res !== x.ev || request_id_res !== x.id || next_wait_ms !== x.wait_ms ||
              queue_empty !== x.empty || last !== x.fin) begin
            failures <= failures + 1;
            if (event_res !== x.ev)
              $error("event_res: expected %0d, actual %0d", x.ev, event_res);
            if (request_id_res !== x.id)
              $error("request_id_res: expected %0d, actual %0d", x.id, request_id_res);
            if (next_wait_ms !== x.wait_ms)
              $error("next_wait_ms: expected %0d, actual %0d", x.wait_ms, next_wait_ms);
            if (queue_empty !== x.empty)
              $error("queue_empty: expected %0d, actual %0d", x.empty, queue_empty);
            if (last !== x.fin)
              $error("last: expected %0d, actual %0d", x.fin, last);
          end
        end
      end
    end
  end
endmodule

### tb/sv/deadline_timer_queue_tb.sv
// ----------------------------------------------------------------------------
// Deadline timer queue testbench
// Drives directed and random timer adds, cancels, ticks and items of an
// unknown kind into the queue with random idle cycles on both channels, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module deadline_timer_queue_tb;
  import dtq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [KIND_W-1:0] kind = KIND_TICK;
  logic [ID_W-1:0] request_id = '0;
  logic [TMO_W-1:0] timeout_ms = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [EV_W-1:0] event_res;
  logic [ID_W-1:0] request_id_res;
  logic [TMO_W-1:0] next_wait_ms;
  logic queue_empty;
  logic last;
  int failures, pending, held_entries;
  int quiet_cycles = 0;
  logic calm = 1'b0;

  always #4 clk = ~clk;

  deadline_timer_queue dut (.*);
  deadline_timer_queue_checker checker_i (.*);

  always @(posedge clk) begin
    result_stall <= (!calm && $urandom_range(99) < 16);
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(logic [KIND_W-1:0] k, logic [ID_W-1:0] rid,
                           logic [TMO_W-1:0] tmo);
    while (!calm && $urandom_range(99) < 16) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    kind <= k;
    request_id <= rid;
    timeout_ms <= tmo;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed part: empty queue, extremes, duplicates, wrap-free ties.
    send_item(KIND_TICK, 8'h00, '0);
    send_item(KIND_CANCEL, 8'hFF, '0);
    send_item(KIND_ADD, 8'h00, '0);
    send_item(KIND_ADD, 8'hFF, 20'hFFFFF);
    send_item(KIND_ADD, 8'h55, 20'd2);
    send_item(KIND_ADD, 8'hAA, 20'd2);
    send_item(KIND_ADD, 8'h55, 20'd2);
    send_item(KIND_CANCEL, 8'h55, '0);
    send_item(KIND_CANCEL, 8'h00, '0);
    send_item(2'd3, 8'h12, 20'h12345);
    send_item(KIND_TICK, 8'hFF, 20'hFFFFF);
    send_item(KIND_TICK, 8'h00, '0);
    send_item(KIND_CANCEL, 8'hFF, '0);
    send_item(KIND_TICK, 8'h00, '0);
    drain_results();
    // Fill past the depth, then cancel one entry and tick to expire entries.
    for (int i = 0; i < DEF_QUEUE_DEPTH + 2; i++)
      send_item(KIND_ADD, 8'(i), 20'(i % 3));
    send_item(KIND_CANCEL, 8'd1, '0);
    send_item(KIND_TICK, 8'h00, '0);
    send_item(KIND_TICK, 8'h00, '0);
    send_item(KIND_TICK, 8'h00, '0);
    drain_results();
    // Random part.
    for (int n = 0; n < 96; n++) begin
      calm = (n >= 30 && n < 60);
      pick = $urandom_range(99);
      if (n == 70) drain_results();
      if (pick < 40 && held_entries < DEF_QUEUE_DEPTH + 2)
        send_item(KIND_ADD, 8'($urandom_range(15)),
                  ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(12)));
      else if (pick < 40 || pick < 62)
        send_item(KIND_TICK, 8'($urandom), 20'($urandom));
      else if (pick < 95)
        send_item(KIND_CANCEL, ($urandom_range(3) == 0) ? 8'($urandom) :
                  8'($urandom_range(15)), 20'($urandom));
      else
        send_item(2'd3, 8'($urandom), 20'($urandom));
    end
    calm = 1'b0;
    drain_results();
    repeat (200) @(posedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
